### design/fbr_pkg.sv
package fbr_pkg;

   // number of header bytes matched before the payload starts (1 or 2)
   localparam int HEADER_LEN = 2;

   // a candidate must be seen on this many further ticks to be confirmed
   localparam logic [1:0] CONFIRM_REPEATS = 2'd2;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_TERMINATOR  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_WORD = 4'd1;

   typedef enum logic {
      FUNC_BYTE = 1'b0,
      FUNC_TICK = 1'b1
   } fbr_func_type;

   // one processing step, shared by the parser and the confirm unit
   typedef struct packed {
      logic       fire_byte;
      logic       fire_tick;
      logic [7:0] rx_byte;
   } fbr_step_type;

endpackage

### design/fbr_parser.sv
module fbr_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  fbr_pkg::fbr_step_type step,
   input  logic [7:0]           terminator,
   input  logic [15:0]          header_word,
   output logic [7:0]           candidate
);
   import fbr_pkg::*;

   logic [1:0] header_pos_ff, header_pos_in;
   logic       in_payload_ff, in_payload_in;
   logic       window_done_ff, window_done_in;
   logic [7:0] payload_sum_ff, payload_sum_in;
   logic [7:0] candidate_ff, candidate_in;
   logic [7:0] expected_byte;
   logic [2:0] pos_plus_one;

   assign expected_byte = header_pos_ff[0] ? header_word[15:8] : header_word[7:0];
   assign pos_plus_one  = {1'b0, header_pos_ff} + 3'd1;

   always_comb begin
      header_pos_in  = header_pos_ff;
      in_payload_in  = in_payload_ff;
      window_done_in = window_done_ff;
      payload_sum_in = payload_sum_ff;
      candidate_in   = candidate_ff;
      if (step.fire_tick) begin
         header_pos_in  = 2'd0;
         in_payload_in  = 1'b0;
         window_done_in = 1'b0;
         payload_sum_in = 8'd0;
      end else if (step.fire_byte && !window_done_ff) begin
         if (in_payload_ff) begin
            if (step.rx_byte == terminator) begin
               candidate_in   = payload_sum_ff;
               payload_sum_in = 8'd0;
               window_done_in = 1'b1;
            end else begin
               payload_sum_in = payload_sum_ff + step.rx_byte;
            end
         end else if (step.rx_byte == expected_byte) begin
            header_pos_in = pos_plus_one[1:0];
            if (pos_plus_one >= 3'(HEADER_LEN)) begin
               in_payload_in = 1'b1;
            end
         end else begin
            window_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pos_ff  <= 2'd0;
         in_payload_ff  <= 1'b0;
         window_done_ff <= 1'b0;
         payload_sum_ff <= 8'd0;
         candidate_ff   <= 8'd0;
      end else begin
         header_pos_ff  <= header_pos_in;
         in_payload_ff  <= in_payload_in;
         window_done_ff <= window_done_in;
         payload_sum_ff <= payload_sum_in;
         candidate_ff   <= candidate_in;
      end
   end

   assign candidate = candidate_ff;

   // payload phase only after the whole header matched
   assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> header_pos_ff == 2'(HEADER_LEN))
      else $error("payload phase entered without a full header");

endmodule

### design/fbr_confirm.sv
module fbr_confirm (
   input  logic                 clock,
   input  logic                 reset,
   input  fbr_pkg::fbr_step_type step,
   input  logic [7:0]           candidate,
   output logic                 changed,
   output logic [7:0]           message
);
   import fbr_pkg::*;

   logic [7:0] confirmed_ff, confirmed_in;
   logic [7:0] last_seen_ff, last_seen_in;
   logic [1:0] repeat_count_ff, repeat_count_in;
   logic       chg;

   always_comb begin
      confirmed_in    = confirmed_ff;
      last_seen_in    = last_seen_ff;
      repeat_count_in = repeat_count_ff;
      chg             = 1'b0;
      if (step.fire_tick && candidate != confirmed_ff) begin
         if (candidate != last_seen_ff) begin
            repeat_count_in = 2'd0;
            last_seen_in    = candidate;
         end else begin
            if (repeat_count_ff < CONFIRM_REPEATS) begin
               repeat_count_in = repeat_count_ff + 2'd1;
            end
            if (repeat_count_in >= CONFIRM_REPEATS) begin
               chg          = 1'b1;
               confirmed_in = candidate;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         confirmed_ff    <= 8'd0;
         last_seen_ff    <= 8'd0;
         repeat_count_ff <= 2'd0;
      end else begin
         confirmed_ff    <= confirmed_in;
         last_seen_ff    <= last_seen_in;
         repeat_count_ff <= repeat_count_in;
      end
   end

   assign changed = chg;
   assign message = confirmed_in;

   assert property (@(posedge clock) disable iff (reset)
      repeat_count_ff <= CONFIRM_REPEATS)
      else $error("repeat count past saturation");

   // a change is only ever reported with a value that differs from the old one
   assert property (@(posedge clock) disable iff (reset)
      chg |=> confirmed_ff != $past(confirmed_ff))
      else $error("change reported without a new message");

endmodule

### design/framed_byte_receiver_with_confirm_top.sv
// framed byte receiver with confirmation
//
// req channel: one item per received byte (req_func = 0, byte on req_rx_byte)
// or per end-of-window tick (req_func = 1). bytes produce no response; each
// tick produces exactly one rsp item with rsp_changed and rsp_message.
// csr channel: csr_index 0 writes the terminator byte, 1 the 16-bit header
// word (first expected byte in the low eight bits); other indexes are
// dropped. csr_ready is always high; write only while the block is idle.
// path: an accepted tick passes through the input register, then the result
// register, which shows its rsp item.
// throughput: one item per cycle, limited only by the single result
// register; bytes keep flowing while a tick result waits in it.
// when the receiver holds rsp_ready low, the pending tick result stays put
// and a second tick stalls in the input register, which then drops req_ready.
// reset (synchronous, active high) clears the configuration, the frame
// parser, the candidate and the confirmed message to zero.
module framed_byte_receiver_with_confirm_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_changed,
   output logic [7:0]                        rsp_message,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fbr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fbr_pkg::*;

   // configuration registers
   logic [7:0]  terminator_ff;
   logic [15:0] header_word_ff;

   // input register
   logic        stage_valid_ff;
   logic        stage_func_ff;
   logic [7:0]  stage_byte_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_changed_ff;
   logic [7:0]  rsp_message_ff;

   logic         stage_advance;
   logic         req_fire;
   fbr_step_type step;
   logic [7:0]   candidate;
   logic         changed;
   logic [7:0]   message;

   // a byte never needs the result register; a tick needs it free or draining
   assign stage_advance = stage_valid_ff &&
                          (stage_func_ff == FUNC_BYTE || !rsp_valid_ff || rsp_ready);
   assign req_ready     = !stage_valid_ff || stage_advance;
   assign req_fire      = req_valid && req_ready;
   assign csr_ready     = 1'b1;

   assign step.fire_byte = stage_advance && stage_func_ff == FUNC_BYTE;
   assign step.fire_tick = stage_advance && stage_func_ff == FUNC_TICK;
   assign step.rx_byte   = stage_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         terminator_ff  <= 8'd0;
         header_word_ff <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TERMINATOR: begin
               terminator_ff <= csr_wdata[7:0];
            end
            CSR_HEADER_WORD: begin
               header_word_ff <= csr_wdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input register: refills in the same cycle it hands its item on
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_func_ff <= req_func;
         stage_byte_ff <= req_rx_byte;
      end
   end

   fbr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .terminator  (terminator_ff),
      .header_word (header_word_ff),
      .candidate   (candidate)
   );

   fbr_confirm u_confirm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .candidate (candidate),
      .changed   (changed),
      .message   (message)
   );

   // result register: loads on a tick, empties when the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step.fire_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.fire_tick) begin
         rsp_changed_ff <= changed;
         rsp_message_ff <= message;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_changed = rsp_changed_ff;
   assign rsp_message = rsp_message_ff;

   // a tick always leaves a result behind
   assert property (@(posedge clock) disable iff (reset)
      step.fire_tick |=> rsp_valid_ff)
      else $error("tick processed without a result");

   // a tick stuck behind an untaken result blocks the input side
   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && stage_func_ff == FUNC_TICK && rsp_valid_ff && !rsp_ready
         |-> !req_ready && !step.fire_tick)
      else $error("tick overran a pending result");

endmodule
